// ===== rtl/pnmru_pkg.sv =====
// shared types and constants for the netpbm binary raster unpacker
// no dependencies; imported by the front end, back end, top level and testbench

package pnmru_pkg;

  // register map, one 32-bit register every four bytes
  typedef enum logic [2:0] {
    REG_BITMAP_MODE  = 3'd0,
    REG_MAX_VALUE    = 3'd1,
    REG_IMAGE_WIDTH  = 3'd2,
    REG_IMAGE_HEIGHT = 3'd3,
    REG_PLANE_COUNT  = 3'd4
  } reg_idx_t;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  // largest max_value that still means one-byte samples
  localparam logic [15:0] ONE_BYTE_MAX  = 16'h00ff;
  localparam int unsigned PIX_PER_BYTE  = 8;
  localparam logic [2:0]  TOP_BIT       = 3'd7;

  // reset values of the registers
  localparam logic [15:0] MAX_VALUE_RST = 16'd255;
  localparam logic [12:0] SIZE_RST      = 13'd1;
  localparam logic [4:0]  PLANES_RST    = 5'd1;

  // register file contents
  typedef struct packed {
    logic        bitmap_mode;
    logic [15:0] max_value;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [4:0]  plane_count;
  } cfg_t;

  // one classified word handed from front to back
  typedef struct packed {
    logic        bitmap;     // data[7:0] holds up to eight packed pixels
    logic [15:0] data;       // sample value, or the raw byte in bitmap mode
    logic [3:0]  plane;
    logic [23:0] pix;        // pixel index of the first result
    logic [2:0]  last_idx;   // number of results minus one
    logic        loi;        // final result closes the image
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/pnmru_front.sv =====
// front end: accepts raster bytes, tracks position in the frame and classifies
// each byte into a queue entry; depends on pnmru_pkg

module pnmru_front #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned MAX_PLANES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pnmru_pkg::cfg_t   cfg,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              q_full,
  output logic              q_push,
  output pnmru_pkg::entry_t q_entry
);
  import pnmru_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PLW = $clog2(MAX_PLANES + 1);

  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [23:0]    pix_r, pix_nxt;
  logic [PLW-1:0] plane_r, plane_nxt;
  logic [7:0]     high_r, high_nxt;
  logic           expect_r, expect_nxt;

  logic [CW-1:0]  eff_w;
  logic [RW-1:0]  eff_h;
  logic [PLW-1:0] eff_p;
  logic [CW-1:0]  col_n, rem, col_adv;
  logic [RW-1:0]  row_n;
  logic [23:0]    pix_n;
  logic [PLW-1:0] plane_cur;
  logic [3:0]     nbits, step;
  logic           row_last, col_last, plane_last, two_byte, accept;
  logic [15:0]    sample;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // register values clamped to the supported range
  always_comb begin
    if (cfg.image_width == '0) begin
      eff_w = CW'(1);
    end else if (32'(cfg.image_width) > MAX_WIDTH) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      eff_h = RW'(1);
    end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
      eff_h = RW'(MAX_HEIGHT);
    end else begin
      eff_h = RW'(cfg.image_height);
    end
    if (cfg.plane_count == '0) begin
      eff_p = PLW'(1);
    end else if (32'(cfg.plane_count) > MAX_PLANES) begin
      eff_p = PLW'(MAX_PLANES);
    end else begin
      eff_p = PLW'(cfg.plane_count);
    end
  end

  // bring the position back inside a frame that may have shrunk
  always_comb begin
    col_n = col_r;
    row_n = row_r;
    pix_n = pix_r;
    if (row_r >= eff_h) begin
      row_n = '0;
      col_n = '0;
      pix_n = '0;
    end
    if (col_n >= eff_w) begin
      col_n = '0;
      if (row_n == eff_h - RW'(1)) begin
        row_n = '0;
        pix_n = '0;
      end else begin
        row_n = row_n + RW'(1);
      end
    end
  end

  assign row_last  = (row_n == eff_h - RW'(1));
  assign col_last  = (col_n == eff_w - CW'(1));
  assign rem       = eff_w - col_n;
  assign nbits     = (32'(rem) > PIX_PER_BYTE) ? 4'(PIX_PER_BYTE) : 4'(rem);
  assign plane_cur = (plane_r >= eff_p) ? '0 : plane_r;
  assign plane_last = (plane_cur == eff_p - PLW'(1));
  assign two_byte  = (cfg.max_value > ONE_BYTE_MAX);
  assign sample    = two_byte ? {high_r, in_tdata} : {8'h00, in_tdata};

  // classify the byte and work out the next position
  always_comb begin
    high_nxt   = high_r;
    expect_nxt = expect_r;
    plane_nxt  = plane_cur;
    step       = '0;
    q_push     = 1'b0;
    q_entry    = '0;
    if (cfg.bitmap_mode) begin
      expect_nxt       = 1'b0;
      plane_nxt        = '0;
      step             = nbits;
      q_push           = accept;
      q_entry.bitmap   = 1'b1;
      q_entry.data     = {8'h00, in_tdata};
      q_entry.pix      = pix_n;
      q_entry.last_idx = 3'(nbits - 4'd1);
      q_entry.loi      = (32'(rem) <= PIX_PER_BYTE) && row_last;
    end else if (two_byte && !expect_r) begin
      // high byte: held until its partner arrives
      high_nxt   = in_tdata;
      expect_nxt = 1'b1;
    end else begin
      expect_nxt       = 1'b0;
      q_push           = accept;
      q_entry.data     = sample;
      q_entry.plane    = 4'(plane_cur);
      q_entry.pix      = pix_n;
      q_entry.loi      = plane_last && col_last && row_last;
      plane_nxt        = plane_last ? '0 : plane_cur + PLW'(1);
      step             = plane_last ? 4'd1 : 4'd0;
    end
  end

  // advance by the pixels this byte used up
  always_comb begin
    col_adv = col_n + CW'(step);
    col_nxt = col_adv;
    row_nxt = row_n;
    pix_nxt = pix_n + 24'(step);
    if (col_adv >= eff_w) begin
      col_nxt = '0;
      if (row_last) begin
        row_nxt = '0;
        pix_nxt = '0;
      end else begin
        row_nxt = row_n + RW'(1);
      end
    end
  end

  // position and pending high byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      pix_r    <= '0;
      plane_r  <= '0;
      high_r   <= '0;
      expect_r <= 1'b0;
    end else if (accept) begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      pix_r    <= pix_nxt;
      plane_r  <= plane_nxt;
      high_r   <= high_nxt;
      expect_r <= expect_nxt;
    end
  end

  // column can never leave the widest supported row
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_r) < MAX_WIDTH)
    else $error("column register beyond widest row");

endmodule

// ===== rtl/pnmru_fifo.sv =====
// small flop-based queue between front and back
// no dependencies; depth must be a power of two of at least two

module pnmru_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0]  count_r, count_nxt;

  assign full  = (count_r == CNTW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNTW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + AW'(1);
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");

endmodule

// ===== rtl/pnmru_back.sv =====
// back end: expands queue entries into output words, one per cycle while the
// output is ready, behind a registered output stage; depends on pnmru_pkg

module pnmru_back (
  input  logic              clk,
  input  logic              rst_n,
  input  pnmru_pkg::entry_t head,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,
  output logic              out_tlast,
  output logic              out_tuser
);
  import pnmru_pkg::*;

  logic [2:0]  idx_r, idx_nxt;
  logic        valid_r;
  logic [15:0] sample_r, sample_nxt;
  logic [3:0]  plane_r;
  logic [23:0] pix_r, pix_nxt;
  logic        lob_r, loi_r;
  logic        load, last, bit_val;

  assign load    = !q_empty && (!valid_r || out_tready);
  assign last    = (idx_r == head.last_idx);
  assign q_pop   = load && last;
  assign bit_val = head.data[{1'b0, TOP_BIT - idx_r}];

  // result for the current position inside the entry
  always_comb begin
    sample_nxt = head.bitmap ? {15'd0, !bit_val} : head.data;
    pix_nxt    = head.pix + 24'(idx_r);
    idx_nxt    = last ? 3'd0 : idx_r + 3'd1;
  end

  // output register and expansion counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= idx_nxt;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sample_r <= sample_nxt;
      plane_r  <= head.plane;
      pix_r    <= pix_nxt;
      lob_r    <= last;
      loi_r    <= head.loi && last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {4'd0, pix_r, plane_r, sample_r};
  assign out_tlast  = loi_r;
  assign out_tuser  = lob_r;

  // image end always closes the word that produced it
  a_loi_ends_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("image end not on last result of a word");

  // expansion counter never runs past the entry
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> idx_r <= head.last_idx)
    else $error("expansion index past entry");

endmodule

// ===== rtl/pnm_binary_raster_unpacker.sv =====
// top level of the netpbm binary raster unpacker: register file, front end,
// queue and back end; depends on pnmru_pkg, pnmru_front, pnmru_fifo, pnmru_back
//
//  channel | direction | handshake             | payload
//  in_     | slave     | tvalid/tready         | tdata[7:0] data_byte
//  out_    | master    | tvalid/tready         | tdata sample/plane/pixel, tlast, tuser
//  cfg_    | apb slave | psel/penable, pready  | paddr[4:2] register, pwdata, prdata
//
// one input byte can be accepted every cycle while the queue has room.
// a sample-mode byte gives at most one result, a bitmap byte one to eight,
// issued one per cycle by the back end while the output is ready, so bitmap input
// is held by the queue once it fills; an accepted byte goes into the queue, then
// into the output register. rst_n is synchronous; it clears position, queue and
// output valid. a stalled output holds its word while the front keeps taking bytes.

module pnm_binary_raster_unpacker #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned MAX_PLANES = 16,
  parameter int unsigned Q_DEPTH    = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] data_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] sample, [19:16] plane_index, [43:20] pixel_index, [47:44] zero
  output logic [47:0]                    out_tdata,
  output logic                           out_tlast,  // last_of_image
  output logic                           out_tuser,  // [0] last_of_byte
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [pnmru_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [pnmru_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [pnmru_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                           cfg_pready
);
  import pnmru_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t reg_sel;
  logic     cfg_wr;
  logic     q_push, q_pop, q_full, q_empty;
  entry_t   q_in, q_head;
  logic [ENTRY_W-1:0] q_rdata;

  assign cfg_pready = 1'b1;
  assign reg_sel    = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bitmap_mode  <= 1'b0;
      cfg_r.max_value    <= MAX_VALUE_RST;
      cfg_r.image_width  <= SIZE_RST;
      cfg_r.image_height <= SIZE_RST;
      cfg_r.plane_count  <= PLANES_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_BITMAP_MODE:  cfg_r.bitmap_mode  <= cfg_pwdata[0];
        REG_MAX_VALUE:    cfg_r.max_value    <= cfg_pwdata[15:0];
        REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_pwdata[12:0];
        REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_pwdata[12:0];
        REG_PLANE_COUNT:  cfg_r.plane_count  <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      REG_BITMAP_MODE:  cfg_prdata = CFG_DW'(cfg_r.bitmap_mode);
      REG_MAX_VALUE:    cfg_prdata = CFG_DW'(cfg_r.max_value);
      REG_IMAGE_WIDTH:  cfg_prdata = CFG_DW'(cfg_r.image_width);
      REG_IMAGE_HEIGHT: cfg_prdata = CFG_DW'(cfg_r.image_height);
      REG_PLANE_COUNT:  cfg_prdata = CFG_DW'(cfg_r.plane_count);
      default:          cfg_prdata = '0;
    endcase
  end

  pnmru_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_PLANES (MAX_PLANES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  pnmru_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_in),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign q_head = entry_t'(q_rdata);

  pnmru_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== tb/pnm_binary_raster_unpacker_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for pnm_binary_raster_unpacker: a scoreboard class predicts
// the samples of each accepted byte and checks the result stream in order
// depends on pnmru_pkg and the rtl of the block

module pnm_binary_raster_unpacker_tb;
  import pnmru_pkg::*;

  localparam int unsigned WIDTH_LIMIT  = 4096;
  localparam int unsigned HEIGHT_LIMIT = 4096;
  localparam int unsigned PLANE_LIMIT  = 16;
  localparam int unsigned PRINT_LIMIT  = 40;

  typedef struct packed {
    logic [15:0] sample;
    logic [3:0]  plane;
    logic [23:0] pix;
    logic        lob;   // last of byte
    logic        loi;   // last of image
  } raster_result_t;

  // mirrors registers and raster position, keeps the samples still owed
  class raster_scoreboard;
    bit          bitmap_mode;
    bit [15:0]   max_value;
    bit [12:0]   width_reg;
    bit [12:0]   height_reg;
    bit [4:0]    planes_reg;
    int unsigned column;
    int unsigned row;
    int unsigned cur_plane;
    bit [23:0]   pixel_count;
    bit [7:0]    high_byte;
    bit          low_pending;
    raster_result_t expected_samples[$];
    int errors;
    int words_in;
    int words_out;

    function new();
      bitmap_mode = 1'b0;
      max_value   = MAX_VALUE_RST;
      width_reg   = SIZE_RST;
      height_reg  = SIZE_RST;
      planes_reg  = PLANES_RST;
      column      = 0;
      row         = 0;
      cur_plane   = 0;
      pixel_count = '0;
      high_byte   = '0;
      low_pending = 1'b0;
      errors      = 0;
      words_in    = 0;
      words_out   = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned cols();
      return clamp(32'(width_reg), WIDTH_LIMIT);
    endfunction

    function int unsigned rows();
      return clamp(32'(height_reg), HEIGHT_LIMIT);
    endfunction

    function int unsigned planes();
      return clamp(32'(planes_reg), PLANE_LIMIT);
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction

    // append one owed sample at the tail
    function void owe(raster_result_t r);
      expected_samples.insert(expected_samples.size(), r);
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_BITMAP_MODE:  bitmap_mode = v[0];
        REG_MAX_VALUE:    max_value   = v[15:0];
        REG_IMAGE_WIDTH:  width_reg   = v[12:0];
        REG_IMAGE_HEIGHT: height_reg  = v[12:0];
        REG_PLANE_COUNT:  planes_reg  = v[4:0];
        default: ;
      endcase
    endfunction

    // a position left outside a shrunken image wraps before the byte is used
    function void normalize();
      if (row >= rows()) begin
        row = 0;
        column = 0;
        pixel_count = '0;
      end
      if (column >= cols()) begin
        column = 0;
        row++;
        if (row >= rows()) begin
          row = 0;
          pixel_count = '0;
        end
      end
    endfunction

    function bit at_last_pixel();
      return (column + 1 >= cols()) && (row + 1 >= rows());
    endfunction

    function void next_pixel();
      column++;
      pixel_count++;
      if (column >= cols()) begin
        column = 0;
        row++;
        if (row >= rows()) begin
          row = 0;
          pixel_count = '0;
        end
      end
    endfunction

    // works out the samples that one raster byte yields
    function void unpack_byte(logic [7:0] b);
      int unsigned n;
      int unsigned np;
      raster_result_t r;
      words_in++;
      normalize();

      // bitmap: up to eight pixels from bit 7 down, set bit is black (0)
      if (bitmap_mode) begin
        low_pending = 1'b0;
        cur_plane = 0;
        n = cols() - column;
        if (n > PIX_PER_BYTE) n = PIX_PER_BYTE;
        for (int unsigned i = 0; i < n; i++) begin
          r.sample = b[3'(TOP_BIT - i)] ? 16'd0 : 16'd1;
          r.plane  = '0;
          r.pix    = pixel_count;
          r.lob    = (i + 1 == n);
          r.loi    = at_last_pixel();
          owe(r);
          next_pixel();
        end
        return;
      end

      // multi-level: one sample per byte, or per big-endian byte pair
      np = planes();
      if (cur_plane >= np) cur_plane = 0;
      if (max_value > ONE_BYTE_MAX) begin
        if (!low_pending) begin
          high_byte = b;
          low_pending = 1'b1;
          return;
        end
        r.sample = {high_byte, b};
      end else begin
        r.sample = {8'h00, b};
      end
      low_pending = 1'b0;
      r.plane = cur_plane[3:0];
      r.pix   = pixel_count;
      r.lob   = 1'b1;
      r.loi   = (cur_plane + 1 >= np) && at_last_pixel();
      owe(r);
      cur_plane++;
      if (cur_plane >= np) begin
        cur_plane = 0;
        next_pixel();
      end
    endfunction

    task report(string msg);
      if (errors < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_sample(raster_result_t got);
      raster_result_t want;
      words_out++;
      if (expected_samples.size() == 0) begin
        report($sformatf("unexpected sample %h plane %0d pixel %0d", got.sample, got.plane,
                         got.pix));
        return;
      end
      want = expected_samples.pop_front();
      if (got.sample !== want.sample || got.plane !== want.plane || got.pix !== want.pix ||
          got.lob !== want.lob || got.loi !== want.loi)
        report($sformatf({"word %0d got/exp sample %h/%h plane %0d/%0d pixel %0d/%0d",
                          " lob %b/%b loi %b/%b"},
                         words_out, got.sample, want.sample, got.plane, want.plane, got.pix,
                         want.pix, got.lob, want.lob, got.loi, want.loi));
    endtask

    task flush_missing();
      raster_result_t want;
      while (expected_samples.size() != 0) begin
        want = expected_samples.pop_front();
        report($sformatf("missing sample %h plane %0d pixel %0d", want.sample, want.plane,
                         want.pix));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic        cfg_pready;

  raster_scoreboard sb;
  raster_result_t   seen;
  int send_idle_pct;
  int stall_pct;
  int hold_cycles;
  int settings_count;

  pnm_binary_raster_unpacker uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // input monitor: every accepted word feeds the predictor
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.unpack_byte(in_tdata);
  end

  // output monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.sample = out_tdata[15:0];
      seen.plane  = out_tdata[19:16];
      seen.pix    = out_tdata[43:20];
      seen.lob    = out_tuser;
      seen.loi    = out_tlast;
      sb.check_sample(seen);
    end
  end

  // receiver: random stalls, or a long hold-off while hold_cycles runs down
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready = 1'b0;
      hold_cycles--;
    end else begin
      out_tready = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one word, with random idle cycles first, and wait for acceptance
  task automatic send_word(input logic [7:0] b);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_bytes(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_word(bytes[i]);
  endtask

  // drop valid, wait for every owed sample, then let a held high byte settle
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // register write followed by a read-back of the same register
  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] v);
    logic [31:0] mask;
    case (idx)
      REG_BITMAP_MODE:  mask = 32'h1;
      REG_MAX_VALUE:    mask = 32'hffff;
      REG_IMAGE_WIDTH:  mask = 32'h1fff;
      REG_IMAGE_HEIGHT: mask = 32'h1fff;
      default:          mask = 32'h1f;
    endcase
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = v;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== (v & mask))
      sb.report($sformatf("register %s reads %h, wrote %h", idx.name(), cfg_prdata, v));
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic apply_settings(input logic mode, input logic [15:0] maxv,
                                input logic [12:0] w, input logic [12:0] h,
                                input logic [4:0] np);
    settle();
    cfg_write(REG_BITMAP_MODE, {31'd0, mode});
    cfg_write(REG_MAX_VALUE, {16'd0, maxv});
    cfg_write(REG_IMAGE_WIDTH, {19'd0, w});
    cfg_write(REG_IMAGE_HEIGHT, {19'd0, h});
    cfg_write(REG_PLANE_COUNT, {27'd0, np});
    settings_count++;
  endtask

  // random image shape, mostly small so that frames complete often
  task automatic random_settings();
    logic [15:0] maxv;
    logic [12:0] w;
    logic [12:0] h;
    logic [4:0]  np;
    case ($urandom_range(5))
      0: maxv = 16'd1;
      1: maxv = 16'd255;
      2: maxv = 16'd256;
      3: maxv = 16'd65535;
      default: maxv = 16'($urandom_range(65535, 1));
    endcase
    case ($urandom_range(9))
      0: w = 13'd0;
      1: w = 13'd4096;
      2: w = 13'($urandom_range(8191, 4097));
      default: w = 13'($urandom_range(20, 1));
    endcase
    case ($urandom_range(7))
      0: h = 13'd0;
      1: h = 13'($urandom_range(8191, 4096));
      default: h = 13'($urandom_range(4, 1));
    endcase
    case ($urandom_range(5))
      0: np = 5'd0;
      1: np = 5'($urandom_range(31, 16));
      default: np = 5'($urandom_range(4, 1));
    endcase
    apply_settings(1'($urandom_range(1)), maxv, w, h, np);
  endtask

  initial begin
    int waited;
    sb = new();
    send_idle_pct  = 0;
    stall_pct      = 0;
    hold_cycles    = 0;
    settings_count = 0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset shape: a one-pixel one-plane image
    send_word(8'h5c);

    // three planes, then fewer planes and a narrower row mid-frame
    apply_settings(1'b0, 16'd255, 13'd3, 13'd2, 5'd3);
    send_bytes({8'h00, 8'hff, 8'h80, 8'h01, 8'h7f});
    settle();
    cfg_write(REG_PLANE_COUNT, 32'd2);
    cfg_write(REG_IMAGE_WIDTH, 32'd1);
    send_bytes({8'haa, 8'h55});

    // two-byte samples, then a high byte left waiting
    settle();
    cfg_write(REG_MAX_VALUE, 32'd65535);
    send_bytes({8'h12, 8'h34, 8'hff, 8'hff, 8'hab});

    // one-byte samples again while the low byte is still awaited
    settle();
    cfg_write(REG_MAX_VALUE, 32'd255);
    send_word(8'hcd);

    // bitmap rows of eleven pixels drop five padding bits each
    apply_settings(1'b1, 16'd255, 13'd11, 13'd2, 5'd1);
    send_bytes({8'h00, 8'hff, 8'ha5, 8'h5a});

    // bitmap byte arriving mid-row takes its pixels from the top bits
    apply_settings(1'b0, 16'd255, 13'd5, 13'd1, 5'd1);
    send_bytes({8'h01, 8'h02});
    settle();
    cfg_write(REG_BITMAP_MODE, 32'd1);
    send_word(8'hc3);

    // sizes below and above the legal range are clamped
    apply_settings(1'b0, 16'd255, 13'd0, 13'd0, 5'd0);
    send_bytes({8'h11, 8'hee});
    apply_settings(1'b0, 16'd255, 13'd8191, 13'd8191, 5'd31);
    send_bytes({8'h3c, 8'hc3, 8'h99});

    // random phases cycling through the idling patterns
    for (int ph = 0; ph < 12; ph++) begin
      random_settings();
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 83; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      repeat (38) send_word(8'($urandom_range(255)));
    end

    // long output hold-off with the sender flat out, so the input stalls
    apply_settings(1'b1, 16'd255, 13'd16, 13'd3, 5'd1);
    send_idle_pct = 0;
    stall_pct = 0;
    @(posedge clk);
    hold_cycles = 300;
    repeat (24) send_word(8'($urandom_range(255)));

    // drain
    @(negedge clk);
    in_tvalid = 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    sb.flush_missing();

    $display("covered %0d bytes in and %0d samples out over %0d register settings",
             sb.words_in, sb.words_out, settings_count);
    $display({"bitmap and multi-level modes, one- and two-byte samples,",
              " clamped and resized images"});
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pnmru_pkg.sv
rtl/pnmru_front.sv
rtl/pnmru_fifo.sv
rtl/pnmru_back.sv
rtl/pnm_binary_raster_unpacker.sv
tb/pnm_binary_raster_unpacker_tb.sv
